@@ hw/rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEFAULT_CAPACITY     = 64;
   localparam int DEFAULT_KEY_BITS     = 32;
   localparam int DEFAULT_PAYLOAD_BITS = 32;

   // fixed field widths of the channels
   localparam int KEY_FIELD_BITS     = 32;
   localparam int PAYLOAD_FIELD_BITS = 32;
   localparam int COUNT_FIELD_BITS   = 7;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                          operation;
      logic [KEY_FIELD_BITS-1:0]       time_key;
      logic [PAYLOAD_FIELD_BITS-1:0]   entry_payload;
   } req_data_type;

   typedef struct packed {
      logic [KEY_FIELD_BITS-1:0]       out_time_key;
      logic [PAYLOAD_FIELD_BITS-1:0]   out_payload;
      logic                            out_valid;
      logic [COUNT_FIELD_BITS-1:0]     entry_count;
      logic                            is_empty;
      logic                            is_full;
      logic                            op_error;
   } rsp_data_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

@@ hw/rtl/spq_chan_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_chan_if
// Valid/ready channel carrying one request or response item.
// ----------------------------------------------------------------------------
interface spq_chan_if #(
   parameter type data_type = logic
) ();
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/sorted_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept as a chain of sorted cells, smallest key first.
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  req_if  | in        | operation, time_key, entry_payload
//  rsp_if  | out       | removed entry, count, empty/full, error flag
//
//  One request per cycle; its response is registered and shows in the cycle
//  after acceptance. Every cell compares its key with the incoming key in
//  parallel, so one key compare plus a four-way select sets the cycle.
//  Reset needs no clearing pass: each cell has its own valid bit.
//  A stalled response holds the request side only while the response
//  register is full and not being taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
   parameter int CAPACITY     = spq_pkg::DEFAULT_CAPACITY,
   parameter int KEY_BITS     = spq_pkg::DEFAULT_KEY_BITS,
   parameter int PAYLOAD_BITS = spq_pkg::DEFAULT_PAYLOAD_BITS
) (
   input logic         clock,
   input logic         reset,
   spq_chan_if.sink    req_if,
   spq_chan_if.source  rsp_if
);
   import spq_pkg::*;

   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   logic [KEY_BITS-1:0]     cell_key     [CAPACITY];
   logic [PAYLOAD_BITS-1:0] cell_payload [CAPACITY];
   logic [CAPACITY-1:0]     cell_valid;
   logic [CAPACITY-1:0]     cell_take;

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_data_type        rsp_data_ff,  rsp_data_in;

   req_data_type            req_data;
   logic                    req_fire;
   logic                    is_empty_now;
   logic                    is_full_now;
   cell_ctrl_type           ctrl;
   logic [KEY_BITS-1:0]     new_key;
   logic [PAYLOAD_BITS-1:0] new_payload;

   assign req_data     = req_if.data;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_ff == CNT_BITS'(CAPACITY));
   assign new_key      = KEY_BITS'(req_data.time_key);
   assign new_payload  = PAYLOAD_BITS'(req_data.entry_payload);

   assign ctrl.insert = req_fire && (req_data.operation == OP_ENQUEUE) && !is_full_now;
   assign ctrl.remove = req_fire && (req_data.operation == OP_DEQUEUE) && !is_empty_now;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0]     l_key,     r_key;
      logic [PAYLOAD_BITS-1:0] l_payload, r_payload;
      logic                    l_valid,   l_take, r_valid;

      if (i == 0) begin : g_head
         assign l_key     = '0;
         assign l_payload = '0;
         assign l_valid   = 1'b0;
         assign l_take    = 1'b0;
      end else begin : g_mid
         assign l_key     = cell_key[i-1];
         assign l_payload = cell_payload[i-1];
         assign l_valid   = cell_valid[i-1];
         assign l_take    = cell_take[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign r_key     = '0;
         assign r_payload = '0;
         assign r_valid   = 1'b0;
      end else begin : g_body
         assign r_key     = cell_key[i+1];
         assign r_payload = cell_payload[i+1];
         assign r_valid   = cell_valid[i+1];
      end

      spq_cell #(
         .KEY_BITS     (KEY_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .new_key       (new_key),
         .new_payload   (new_payload),
         .left_key      (l_key),
         .left_payload  (l_payload),
         .left_valid    (l_valid),
         .left_take     (l_take),
         .right_key     (r_key),
         .right_payload (r_payload),
         .right_valid   (r_valid),
         .take          (cell_take[i]),
         .key           (cell_key[i]),
         .payload       (cell_payload[i]),
         .valid         (cell_valid[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CNT_BITS'(1);
      end

      rsp_data_in              = '0;
      rsp_data_in.entry_count  = COUNT_FIELD_BITS'(count_in);
      rsp_data_in.is_empty     = (count_in == '0);
      rsp_data_in.is_full      = (count_in == CNT_BITS'(CAPACITY));
      rsp_data_in.op_error     = req_fire && !ctrl.insert && !ctrl.remove;
      if (ctrl.remove) begin
         rsp_data_in.out_time_key = KEY_FIELD_BITS'(cell_key[0]);
         rsp_data_in.out_payload  = PAYLOAD_FIELD_BITS'(cell_payload[0]);
         rsp_data_in.out_valid    = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(CAPACITY))
      else $error("entry count above capacity");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("cell valid bits disagree with entry count");

   a_head_occupied: assert property (@(posedge clock) disable iff (reset)
      !is_empty_now |-> cell_valid[0])
      else $error("store not left-aligned");

   a_dequeue_returns: assert property (@(posedge clock) disable iff (reset)
      ctrl.remove |=> rsp_valid_ff && rsp_data_ff.out_valid && !rsp_data_ff.op_error)
      else $error("dequeue did not return an entry");
`endif

endmodule

@@ hw/rtl/spq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted store: holds an entry, shifts right on insert
// behind the insertion point and shifts left on remove.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int KEY_BITS     = spq_pkg::DEFAULT_KEY_BITS,
   parameter int PAYLOAD_BITS = spq_pkg::DEFAULT_PAYLOAD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spq_pkg::cell_ctrl_type    ctrl,
   input  logic [KEY_BITS-1:0]       new_key,
   input  logic [PAYLOAD_BITS-1:0]   new_payload,
   input  logic [KEY_BITS-1:0]       left_key,
   input  logic [PAYLOAD_BITS-1:0]   left_payload,
   input  logic                      left_valid,
   input  logic                      left_take,
   input  logic [KEY_BITS-1:0]       right_key,
   input  logic [PAYLOAD_BITS-1:0]   right_payload,
   input  logic                      right_valid,
   output logic                      take,
   output logic [KEY_BITS-1:0]       key,
   output logic [PAYLOAD_BITS-1:0]   payload,
   output logic                      valid
);
   import spq_pkg::*;

   logic [KEY_BITS-1:0]     key_ff,     key_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic                    valid_ff,   valid_in;

   // new entry lands here or further left when this slot is empty or larger
   assign take = !valid_ff || (key_ff > new_key);

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      valid_in   = valid_ff;
      if (ctrl.insert && take) begin
         if (left_take) begin
            key_in     = left_key;
            payload_in = left_payload;
            valid_in   = left_valid;
         end else begin
            key_in     = new_key;
            payload_in = new_payload;
            valid_in   = 1'b1;
         end
      end else if (ctrl.remove) begin
         key_in     = right_key;
         payload_in = right_payload;
         valid_in   = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign key     = key_ff;
   assign payload = payload_ff;
   assign valid   = valid_ff;

endmodule

@@ dv/sorted_priority_queue_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_test
// Drives enqueue and dequeue requests into the sorted priority queue with
// random idling on both channels. A behavioral sorted store predicts each
// response, and the monitor compares the responses field by field in order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_test;
   import spq_pkg::*;

   localparam int QUEUE_CAPACITY = DEFAULT_CAPACITY;
   localparam int TARGET_REQS    = 1150;
   localparam int TAIL_REQS      = 150;
   localparam int HOLD_CYCLES    = 250;
   localparam int MAX_REPORTS    = 40;

   logic clock = 1'b0;
   logic reset;

   spq_chan_if #(.data_type(req_data_type)) req_if ();
   spq_chan_if #(.data_type(rsp_data_type)) rsp_if ();

   sorted_priority_queue_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   req_data_type pending_reqs[$];
   rsp_data_type expected_rsps[$];
   logic [KEY_FIELD_BITS-1:0]     sorted_keys[$];
   logic [PAYLOAD_FIELD_BITS-1:0] sorted_payloads[$];

   int   stim_depth;
   int   req_accepted_count = 0;
   int   rsp_checked_count  = 0;
   int   error_count        = 0;
   int   req_gap            = 0;
   int   rsp_stall          = 0;
   logic rsp_hold           = 1'b0;

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic add_req(op_type op, logic [31:0] key, logic [31:0] payload);
      req_data_type item;
      item.operation     = op;
      item.time_key      = key;
      item.entry_payload = payload;
      pending_reqs.push_back(item);
      // track the occupancy so phases can aim for full and empty
      if (op == OP_ENQUEUE && stim_depth < QUEUE_CAPACITY)
         stim_depth++;
      else if (op == OP_DEQUEUE && stim_depth > 0)
         stim_depth--;
   endtask

   function automatic logic [31:0] random_key();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         return 32'h0000_0000;
      else if (pick < 16)
         return 32'hffff_ffff;
      else if (pick < 45)
         return 32'($urandom_range(0, 15));   // dense keys give many ties
      else if (pick < 60)
         return 32'h8000_0000 + 32'($urandom_range(0, 7)) - 32'd4;
      return $urandom;
   endfunction

   function automatic logic [31:0] random_payload();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         return 32'h0000_0000;
      else if (pick < 10)
         return 32'hffff_ffff;
      return $urandom;
   endfunction

   task automatic add_random_req(int enqueue_pct);
      op_type op;
      op = ($urandom_range(0, 99) < enqueue_pct) ? OP_ENQUEUE : OP_DEQUEUE;
      add_req(op, random_key(), random_payload());
   endtask

   // ---------------------------------------------------------------------------
   // prediction: plain sorted store, ties keep arrival order
   // ---------------------------------------------------------------------------
   task automatic predict_queue_response(req_data_type item);
      rsp_data_type rsp;
      int           pos;
      int           depth;
      rsp   = '0;
      depth = sorted_keys.size();
      if (item.operation == OP_ENQUEUE) begin
         if (depth >= QUEUE_CAPACITY) begin
            rsp.op_error = 1'b1;
         end else begin
            pos = 0;
            while (pos < depth && sorted_keys[pos] <= item.time_key)
               pos++;
            sorted_keys.insert(pos, item.time_key);
            sorted_payloads.insert(pos, item.entry_payload);
         end
      end else begin
         if (depth == 0) begin
            rsp.op_error = 1'b1;
         end else begin
            rsp.out_time_key = sorted_keys.pop_front();
            rsp.out_payload  = sorted_payloads.pop_front();
            rsp.out_valid    = 1'b1;
         end
      end
      depth           = sorted_keys.size();
      rsp.entry_count = COUNT_FIELD_BITS'(depth);
      rsp.is_empty    = (depth == 0);
      rsp.is_full     = (depth >= QUEUE_CAPACITY);
      expected_rsps.push_back(rsp);
   endtask

   task automatic report_mismatch(string field_name, logic [31:0] exp_val,
                                  logic [31:0] act_val);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %h, actual %h",
                  $time, field_name, exp_val, act_val);
   endtask

   task automatic check_response(rsp_data_type act);
      rsp_data_type exp;
      if (expected_rsps.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected response: expected none, actual %h", $time, act);
      end else begin
         exp = expected_rsps.pop_front();
         if (act.out_time_key !== exp.out_time_key)
            report_mismatch("out_time_key", exp.out_time_key, act.out_time_key);
         if (act.out_payload !== exp.out_payload)
            report_mismatch("out_payload", exp.out_payload, act.out_payload);
         if (act.out_valid !== exp.out_valid)
            report_mismatch("out_valid", 32'(exp.out_valid), 32'(act.out_valid));
         if (act.entry_count !== exp.entry_count)
            report_mismatch("entry_count", 32'(exp.entry_count), 32'(act.entry_count));
         if (act.is_empty !== exp.is_empty)
            report_mismatch("is_empty", 32'(exp.is_empty), 32'(act.is_empty));
         if (act.is_full !== exp.is_full)
            report_mismatch("is_full", 32'(exp.is_full), 32'(act.is_full));
         if (act.op_error !== exp.op_error)
            report_mismatch("op_error", 32'(exp.op_error), 32'(act.op_error));
      end
   endtask

   // ---------------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data  <= '0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_queue_response(req_if.data);
            req_accepted_count++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_if.data  <= pending_reqs.pop_front();
               req_if.valid <= 1'b1;
               if (pending_reqs.size() >= TAIL_REQS && $urandom_range(0, 9) == 0)
                  req_gap = $urandom_range(1, 9);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // response monitor
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_response(rsp_if.data);
            rsp_checked_count++;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_hold) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (pending_reqs.size() >= TAIL_REQS && $urandom_range(0, 9) == 0)
               rsp_stall = $urandom_range(1, 9);
         end
      end
   end

   // long hold-off on the response side so the queue backs up into the request side
   initial begin
      int hold_count;
      while (rsp_checked_count < 300)
         @(posedge clock);
      rsp_hold <= 1'b1;
      for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
         @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin
      int total_reqs;
      int phase;
      int len;
      int idx;

      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      stim_depth   = 0;

      // directed: empty dequeue, key and payload extremes, tie order
      add_req(OP_DEQUEUE, 32'hffff_ffff, 32'hffff_ffff);
      add_req(OP_ENQUEUE, 32'h0000_0000, 32'hffff_ffff);
      add_req(OP_ENQUEUE, 32'hffff_ffff, 32'h0000_0000);
      add_req(OP_ENQUEUE, 32'h0000_0005, 32'h0000_0001);
      add_req(OP_ENQUEUE, 32'h0000_0005, 32'h0000_0002);
      add_req(OP_ENQUEUE, 32'h0000_0005, 32'h0000_0003);
      add_req(OP_ENQUEUE, 32'h0000_0000, 32'h5555_5555);
      add_req(OP_ENQUEUE, 32'hffff_ffff, 32'haaaa_aaaa);
      for (idx = 0; idx < 7; idx++)
         add_req(OP_DEQUEUE, 32'h0000_0000, 32'h0000_0000);
      add_req(OP_DEQUEUE, 32'h0000_0000, 32'h0000_0000);
      add_req(OP_ENQUEUE, 32'h8000_0000, 32'h8000_0000);
      add_req(OP_ENQUEUE, 32'h7fff_ffff, 32'h7fff_ffff);
      add_req(OP_DEQUEUE, 32'h5555_5555, 32'haaaa_aaaa);
      add_req(OP_DEQUEUE, 32'haaaa_aaaa, 32'h5555_5555);
      add_req(OP_DEQUEUE, 32'h0000_0000, 32'h0000_0000);

      // random phases: fill to full and push past it, drain past empty, mixed traffic
      while (pending_reqs.size() < TARGET_REQS) begin
         phase = $urandom_range(0, 3);
         if (phase == 0) begin
            while (stim_depth < QUEUE_CAPACITY)
               add_random_req(88);
            len = $urandom_range(1, 3);
            for (idx = 0; idx < len; idx++)
               add_req(OP_ENQUEUE, random_key(), random_payload());
         end else if (phase == 1) begin
            while (stim_depth > 0)
               add_random_req(12);
            len = $urandom_range(1, 3);
            for (idx = 0; idx < len; idx++)
               add_req(OP_DEQUEUE, $urandom, $urandom);
         end else begin
            len = $urandom_range(20, 60);
            for (idx = 0; idx < len; idx++)
               add_random_req(50);
         end
      end
      total_reqs = pending_reqs.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (req_accepted_count < total_reqs)
         @(posedge clock);
      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
